// File: hw/rtl/pucg_pkg.sv
// Shared types, constants and the cycle length table for the permutation
// universal cycle generator. No dependencies.
`timescale 1ns / 1ps

package pucg_pkg;

    // Field widths and defaults
    localparam int SYM_W           = 5;
    localparam int MAX_SYMBOLS_DEF = 20;
    localparam int POS_W           = 62;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;
    localparam int RESET_COUNT     = 4;

    // Register index decoded from paddr[2]
    localparam logic REG_SYMBOL_COUNT = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_CLIMB
    } state_t;

    // Command from the level sequencer to the permutation store
    typedef struct packed {
        logic init;
        logic rotate;
    } perm_cmd_t;

    // n! - 1 for n symbols: index of the final symbol of one cycle
    function automatic logic [POS_W-1:0] cycle_last(input logic [SYM_W-1:0] n);
        logic [POS_W-1:0] v;
        case (n)
            5'd2:    v = 62'd1;
            5'd3:    v = 62'd5;
            5'd4:    v = 62'd23;
            5'd5:    v = 62'd119;
            5'd6:    v = 62'd719;
            5'd7:    v = 62'd5039;
            5'd8:    v = 62'd40319;
            5'd9:    v = 62'd362879;
            5'd10:   v = 62'd3628799;
            5'd11:   v = 62'd39916799;
            5'd12:   v = 62'd479001599;
            5'd13:   v = 62'd6227020799;
            5'd14:   v = 62'd87178291199;
            5'd15:   v = 62'd1307674367999;
            5'd16:   v = 62'd20922789887999;
            5'd17:   v = 62'd355687428095999;
            5'd18:   v = 62'd6402373705727999;
            5'd19:   v = 62'd121645100408831999;
            5'd20:   v = 62'd2432902008176639999;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/pucg_perm_store.sv
// Working permutation array with the shared prefix-rotate unit.
// Depends on pucg_pkg.
`timescale 1ns / 1ps

module pucg_perm_store
    import pucg_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int RESET_N     = RESET_COUNT,
    parameter int IDX_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  perm_cmd_t        cmd,
    input  logic [SYM_W-1:0] count,
    input  logic [IDX_W-1:0] top,
    output logic [SYM_W-1:0] tail
);

    logic [SYM_W-1:0] perm_reg  [MAX_SYMBOLS];
    logic [SYM_W-1:0] perm_next [MAX_SYMBOLS];

    // Element at the top of the prefix; wraps to entry 0 on rotate
    assign tail = perm_reg[top];

    // Reload or rotate the prefix 0..top right by one place
    always_comb
    begin
        perm_next = perm_reg;
        if (cmd.init)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                perm_next[i] = (SYM_W'(i) < count) ? (count - SYM_W'(i)) : '0;
            end
        end
        else if (cmd.rotate)
        begin
            perm_next[0] = tail;
            for (int i = 1; i < MAX_SYMBOLS; i++)
            begin
                if (IDX_W'(i) <= top)
                begin
                    perm_next[i] = perm_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                perm_reg[i] <= (i < RESET_N) ? SYM_W'(RESET_N - i) : '0;
            end
        end
        else
        begin
            perm_reg <= perm_next;
        end
    end

endmodule

// File: hw/rtl/pucg_level_seq.sv
// Level sequencer: per-level call counters, current level and the climb FSM
// that drives the shared rotate unit. Depends on pucg_pkg.
`timescale 1ns / 1ps

module pucg_level_seq
    import pucg_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int RESET_N     = RESET_COUNT,
    parameter int IDX_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             init,
    input  logic [SYM_W-1:0] count,
    input  logic             start,
    output logic             busy,
    output logic [IDX_W-1:0] top,
    output perm_cmd_t        cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] lvl_reg, lvl_next;
    logic [SYM_W-1:0] calls_reg  [MAX_SYMBOLS];
    logic [SYM_W-1:0] calls_next [MAX_SYMBOLS];

    logic [IDX_W-1:0] deepest;
    logic [SYM_W-1:0] calls_inc;
    logic             step;
    logic             done;

    assign deepest   = IDX_W'(count - SYM_W'(1));
    assign calls_inc = calls_reg[lvl_reg] + SYM_W'(1);
    assign step      = ((state_reg == ST_IDLE) && start && (lvl_reg != '0))
                     || (state_reg == ST_CLIMB);
    assign busy      = (state_reg == ST_CLIMB);
    assign top       = lvl_reg;

    // One rotation per cycle; climb while levels finish their calls
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        calls_next = calls_reg;
        cmd        = '0;
        done       = 1'b0;
        if (init)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                calls_next[i] = '0;
            end
            lvl_next   = deepest;
            state_next = ST_IDLE;
            cmd.init   = 1'b1;
        end
        else if (step)
        begin
            cmd.rotate = 1'b1;
            if (calls_inc <= SYM_W'(lvl_reg))
            begin
                calls_next[lvl_reg] = calls_inc;
                done = 1'b1;
            end
            else
            begin
                calls_next[lvl_reg] = '0;
                if (lvl_reg == IDX_W'(1))
                begin
                    done = 1'b1;
                end
                else
                begin
                    lvl_next   = lvl_reg - IDX_W'(1);
                    state_next = ST_CLIMB;
                end
            end
            if (done)
            begin
                lvl_next   = deepest;
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_reg   <= IDX_W'(RESET_N - 1);
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                calls_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            calls_reg <= calls_next;
        end
    end

endmodule

// File: hw/rtl/permutation_universal_cycle_gen_unit.sv
// Top level of the permutation universal cycle generator: register port,
// cycle position counter, output register. Depends on pucg_pkg,
// pucg_perm_store and pucg_level_seq.
`timescale 1ns / 1ps

// Each request transaction with next_request high yields one symbol of a
// shorthand universal cycle over the permutations of n = symbol_count symbols;
// last_of_cycle marks symbol n!, after which the cycle repeats. The symbol is
// taken in the accept cycle, which also performs the deepest level's prefix
// rotation; every further level that completes its calls takes another rotation
// of the single shared rotate unit, during which the sequencer is busy and
// takes no new request. A request with next_request low is consumed with no
// result. The output register lets a request be taken in the cycle that the
// previous symbol is taken, once the sequencer is idle. Writing symbol_count
// (clamped to 1..MAX_SYMBOLS) restarts the cycle; no clearing pass is needed.

module permutation_universal_cycle_gen_unit
    import pucg_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB-style register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              next_request,
    // Symbol channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SYM_W-1:0]  symbol,
    output logic              last_of_cycle
);

    localparam int IDX_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int RESET_N = (MAX_SYMBOLS < RESET_COUNT) ? MAX_SYMBOLS : RESET_COUNT;

    logic [SYM_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] remain_reg, remain_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;

    logic             cfg_write;
    logic [SYM_W-1:0] cfg_raw;
    logic [SYM_W-1:0] cfg_clamped;
    logic             accept;
    logic             request;
    logic             busy;
    logic [IDX_W-1:0] top;
    logic [SYM_W-1:0] tail;
    perm_cmd_t        cmd;

    // Register port decode and clamp
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SYMBOL_COUNT);
    assign cfg_raw   = pwdata[SYM_W-1:0];

    always_comb
    begin
        cfg_clamped = cfg_raw;
        if (cfg_raw == '0)
        begin
            cfg_clamped = SYM_W'(1);
        end
        else if (cfg_raw > SYM_W'(MAX_SYMBOLS))
        begin
            cfg_clamped = SYM_W'(MAX_SYMBOLS);
        end
    end

    assign count_next = cfg_write ? cfg_clamped : count_reg;
    assign prdata     = (paddr[2] == REG_SYMBOL_COUNT) ? DATA_W'(count_reg) : '0;

    // Handshake
    assign in_ready      = !busy && (!out_valid_reg || out_ready);
    assign accept        = in_valid && in_ready;
    assign request       = accept && next_request;
    assign out_valid     = out_valid_reg;
    assign symbol        = symbol_reg;
    assign last_of_cycle = last_reg;

    // Count down symbols left in the cycle; reload on restart or wrap
    always_comb
    begin
        remain_next = remain_reg;
        if (cfg_write)
        begin
            remain_next = cycle_last(cfg_clamped);
        end
        else if (request)
        begin
            remain_next = (remain_reg == '0) ? cycle_last(count_reg)
                                             : remain_reg - POS_W'(1);
        end
    end

    // Hold a result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (request)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= SYM_W'(RESET_N);
            remain_reg    <= cycle_last(SYM_W'(RESET_N));
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (request)
        begin
            symbol_reg <= tail;
            last_reg   <= (remain_reg == '0);
        end
    end

    pucg_level_seq #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .RESET_N     (RESET_N),
        .IDX_W       (IDX_W)
    ) u_level_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (cfg_write),
        .count (count_next),
        .start (request),
        .busy  (busy),
        .top   (top),
        .cmd   (cmd)
    );

    pucg_perm_store #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .RESET_N     (RESET_N),
        .IDX_W       (IDX_W)
    ) u_perm_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .count (count_next),
        .top   (top),
        .tail  (tail)
    );

endmodule

// File: test/permutation_universal_cycle_gen_unit_tb.sv
// Self-checking testbench for permutation_universal_cycle_gen_unit: drives request
// transactions and symbol_count writes, predicts every symbol in a local model of
// the rotation scheme. Depends on pucg_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module permutation_universal_cycle_gen_unit_tb;
    import pucg_pkg::*;

    localparam int                SYM_CAP           = MAX_SYMBOLS_DEF;
    localparam logic [ADDR_W-1:0] SYMBOL_COUNT_ADDR = {REG_SYMBOL_COUNT, 2'b00};
    localparam int                RANDOM_TARGET     = 370;
    localparam int                LONG_HOLD_CYCLES  = 150;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             cycle_end;
    } symbol_expect_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              next_request = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SYM_W-1:0]  symbol;
    logic              last_of_cycle;

    // Pending request bits and symbols still owed by the unit
    logic            pending_reqs[$];
    symbol_expect_t  expected_syms[$];
    int              error_count = 0;

    // Local copy of the generator state
    logic [SYM_W-1:0] perm_model[SYM_CAP];
    logic [SYM_W-1:0] level_done[SYM_CAP];
    int               sym_count;
    longint unsigned  emitted_in_cycle;
    longint unsigned  cycle_len;

    // Handshake bookkeeping for the edge processes
    bit in_accepted = 1'b0;
    int send_gap = 0;
    int send_burst = 0;
    int recv_gap = 0;
    int recv_burst = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    int long_hold_left = 0;

    permutation_universal_cycle_gen_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .next_request  (next_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .symbol        (symbol),
        .last_of_cycle (last_of_cycle)
    );

    always #4 clk = ~clk;

    // Restart the model for the current symbol count
    function automatic void reload_generator();
        longint unsigned f;
        f = 1;
        for (int i = 0; i < SYM_CAP; i++)
        begin
            perm_model[i] = (i < sym_count) ? SYM_W'(sym_count - i) : '0;
            level_done[i] = '0;
        end
        for (int i = 2; i <= sym_count; i++)
            f = f * longint'(i);
        cycle_len        = f;
        emitted_in_cycle = 0;
    endfunction

    // Apply a symbol_count write: low five bits, clamped to 1..SYM_CAP
    function automatic void load_symbol_count(input logic [DATA_W-1:0] word);
        int v;
        v = int'(word[SYM_W-1:0]);
        if (v < 1)
            v = 1;
        if (v > SYM_CAP)
            v = SYM_CAP;
        sym_count = v;
        reload_generator();
    endfunction

    // Rotate perm_model[0..top] right by one place
    function automatic void rotate_prefix(input int top);
        logic [SYM_W-1:0] t;
        t = perm_model[top];
        for (int i = top; i > 0; i--)
            perm_model[i] = perm_model[i - 1];
        perm_model[0] = t;
    endfunction

    // Emit the current leaf symbol, then climb to the next leaf
    function automatic symbol_expect_t next_cycle_symbol();
        symbol_expect_t e;
        int             m;
        e.sym       = perm_model[sym_count - 1];
        e.cycle_end = (emitted_in_cycle + 1 >= cycle_len);
        m = sym_count - 1;
        while (m >= 1)
        begin
            level_done[m] = level_done[m] + 1'b1;
            rotate_prefix(m);
            if (int'(level_done[m]) < m + 1)
                break;
            level_done[m] = '0;
            m--;
        end
        emitted_in_cycle = e.cycle_end ? 0 : emitted_in_cycle + 1;
        return e;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Request driver: hold until accepted, then pause or offer the next transaction
    always @(negedge clk)
    begin
        if (in_valid && !in_accepted)
        begin
            // hold valid and payload
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (rst_n && pending_reqs.size() != 0)
        begin
            in_valid     <= 1'b1;
            next_request <= pending_reqs.pop_front();
            if (send_burst == 0 && $urandom_range(0, 39) == 0)
                send_burst = $urandom_range(20, 40);
            if (send_burst > 0)
            begin
                send_burst--;
                send_gap = 0;
            end
            else
                send_gap = pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // Symbol receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
        end
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (recv_burst == 0 && $urandom_range(0, 39) == 0)
                recv_burst = $urandom_range(20, 40);
            if (recv_burst > 0)
            begin
                recv_burst--;
                recv_gap = 0;
            end
            else
                recv_gap = pick_gap();
        end
    end

    // Monitor: check delivered symbols, then predict for an accepted request
    always @(posedge clk)
    begin
        symbol_expect_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_syms.size() == 0)
                report_mismatch("unexpected symbol", int'(symbol), -1);
            else
            begin
                want = expected_syms.pop_front();
                if (symbol !== want.sym)
                    report_mismatch("symbol", int'(symbol), int'(want.sym));
                if (last_of_cycle !== want.cycle_end)
                    report_mismatch("last_of_cycle", int'(last_of_cycle), int'(want.cycle_end));
            end
        end
        in_accepted = rst_n && in_valid && in_ready;
        if (in_accepted && next_request)
            expected_syms.push_back(next_cycle_symbol());
    end

    // Wait for the unit to drain, then let any request with no result finish
    task automatic settle();
        while (pending_reqs.size() != 0 || in_valid || expected_syms.size() != 0)
            @(posedge clk);
        repeat (SYM_CAP + 8) @(posedge clk);
    endtask

    // Two-phase register write; the model follows at the write edge
    task automatic write_symbol_count(input logic [DATA_W-1:0] word);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SYMBOL_COUNT_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        load_symbol_count(word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Queue random requests, a few with the request bit clear; return the number queued
    function automatic int queue_requests(input int count, input int zero_pct);
        bit b;
        for (int i = 0; i < count; i++)
        begin
            b = ($urandom_range(0, 99) >= zero_pct);
            pending_reqs.push_back(b);
        end
        return count;
    endfunction

    initial
    begin
        int               random_reqs;
        int               n_items;
        int               roll;
        logic [DATA_W-1:0] word;

        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sym_count = RESET_COUNT;
        reload_generator();

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset setting: plain requests and an ignored one
        pending_reqs.push_back(1'b1);
        pending_reqs.push_back(1'b0);
        pending_reqs.push_back(1'b1);
        pending_reqs.push_back(1'b1);
        settle();

        // Zero clamps to one symbol: every request ends a cycle
        write_symbol_count(32'd0);
        repeat (3) pending_reqs.push_back(1'b1);
        settle();

        // Two symbols: cross the end of the cycle twice
        write_symbol_count(32'd2);
        repeat (5) pending_reqs.push_back(1'b1);
        settle();

        // Three symbols: one full cycle and the wrap
        write_symbol_count(32'd3);
        repeat (7) pending_reqs.push_back(1'b1);
        settle();

        // Above the maximum clamps to twenty
        write_symbol_count(32'd31);
        repeat (3) pending_reqs.push_back(1'b1);
        settle();

        // Back to four symbols; hold off the receiver while requests keep coming
        write_symbol_count(32'd4);
        random_reqs = queue_requests(90, 10);
        long_hold_req = 1'b1;
        settle();

        // Random settings, mostly short cycles so the wrap is hit often
        while (random_reqs < RANDOM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                word = $urandom();
            else if (roll < 16)
                word = DATA_W'($urandom_range(7, SYM_CAP));
            else if (roll < 20)
                word = (roll < 18) ? DATA_W'(SYM_CAP) : DATA_W'(1);
            else
                word = DATA_W'($urandom_range(2, 5));
            write_symbol_count(word);
            n_items = $urandom_range(10, 70);
            random_reqs += queue_requests(n_items, $urandom_range(0, 25));
            settle();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
